### hw/rtl/gfc_pkg.sv
// shared constants, types and the log2 distance table for the gamma curve evaluator
package gfc_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] REG_GAMMA = 2'd0;
    localparam logic [1:0] REG_MIN   = 2'd1;
    localparam logic [1:0] REG_MAX   = 2'd2;

    // register reset values, 16.16
    localparam logic [31:0] GAMMA_RESET = 32'd65536;
    localparam logic [31:0] MIN_RESET   = 32'd0;
    localparam logic [31:0] MAX_RESET   = 32'd65536;

    // legal gamma window, 16.16
    localparam logic [31:0] GAMMA_LOW_CODE  = 32'd6554;
    localparam logic [31:0] GAMMA_HIGH_CODE = 32'd655360;

    // ln(2) in Q.32
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F7;

    // side data that rides along the series pipeline
    typedef struct packed {
        logic [7:0] idx;
        logic [6:0] shift;
    } tag_t;

    localparam int TAG_W = $bits(tag_t);

    // log2 of an integer 1..255 in Q.31 by repeated squaring
    function automatic logic [33:0] log2_q31(input logic [7:0] v);
        logic [2:0]  msb;
        logic [63:0] x;
        logic [30:0] frac;
        msb  = 3'd0;
        frac = '0;
        for (int b = 1; b < 8; b++)
        begin
            if (v[b])
            begin
                msb = 3'(b);
            end
        end
        x = 64'(v) << (31 - int'(msb));
        for (int k = 0; k < 31; k++)
        begin
            x = (x * x) >> 31;
            if (x >= 64'h1_0000_0000)
            begin
                x = x >> 1;
                frac[30 - k] = 1'b1;
            end
        end
        return {msb, frac};
    endfunction

    typedef logic [33:0] dist_table_t [256];

    // log2(255) - log2(i) for every index, ends unused
    function automatic dist_table_t build_dist_table();
        dist_table_t tbl;
        logic [33:0] top;
        top = log2_q31(8'd255);
        for (int i = 0; i < 256; i++)
        begin
            if (i == 0 || i == 255)
            begin
                tbl[i] = '0;
            end
            else
            begin
                tbl[i] = top - log2_q31(8'(i));
            end
        end
        return tbl;
    endfunction

    localparam dist_table_t DIST_TABLE = build_dist_table();

endpackage

### hw/rtl/gfc_series_term.sv
// one term of the e^-x series: multiply, divide by the term number, accumulate
module gfc_series_term #(
    parameter int K = 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [31:0]               in_term,
    input  logic [31:0]               in_a,
    input  logic [33:0]               in_sum,
    input  logic [gfc_pkg::TAG_W-1:0] in_tag,
    output logic                      out_valid,
    output logic [31:0]               out_term,
    output logic [31:0]               out_a,
    output logic [33:0]               out_sum,
    output logic [gfc_pkg::TAG_W-1:0] out_tag
);

    localparam logic [63:0] RECIP   = 64'((64'd1 << 32) / K);
    localparam logic [31:0] K_CONST = 32'(K);
    localparam logic        ODD     = K_CONST[0];

    logic                      v1_reg, v2_reg, v3_reg;
    logic [31:0]               x1_reg, x2_reg, q0_reg, a1_reg, a2_reg, term3_reg, a3_reg;
    logic [33:0]               sum1_reg, sum2_reg, sum3_reg;
    logic [gfc_pkg::TAG_W-1:0] tag1_reg, tag2_reg, tag3_reg;

    logic [63:0] prod1_next;
    logic [63:0] prod2_next;
    logic [31:0] rem_next;
    logic [31:0] q_next;
    logic [33:0] sum_next;

    // term times a, keep the upper word
    assign prod1_next = 64'(in_term) * 64'(in_a);
    // reciprocal estimate, low by at most one
    assign prod2_next = 64'(x1_reg) * RECIP;

    // correction and accumulation
    always_comb
    begin
        rem_next = x2_reg - 32'(q0_reg * K_CONST);
        q_next   = (rem_next >= K_CONST) ? q0_reg + 32'd1 : q0_reg;
        sum_next = ODD ? sum2_reg - 34'(q_next) : sum2_reg + 34'(q_next);
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        x1_reg    <= prod1_next[63:32];
        a1_reg    <= in_a;
        sum1_reg  <= in_sum;
        tag1_reg  <= in_tag;
        x2_reg    <= x1_reg;
        q0_reg    <= prod2_next[63:32];
        a2_reg    <= a1_reg;
        sum2_reg  <= sum1_reg;
        tag2_reg  <= tag1_reg;
        term3_reg <= q_next;
        a3_reg    <= a2_reg;
        sum3_reg  <= sum_next;
        tag3_reg  <= tag2_reg;
    end

    assign out_valid = v3_reg;
    assign out_term  = term3_reg;
    assign out_a     = a3_reg;
    assign out_sum   = sum3_reg;
    assign out_tag   = tag3_reg;

endmodule

### hw/rtl/gamma_formula_curve_eval.sv
// top level of the gamma formula curve evaluator
//
// usage: configure gamma_code, min_code and max_code (16.16) through the
// cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) while idle;
// cfg_ready is always high and index 3 is ignored.
// an entry_index beat is taken on each edge with start high and busy low;
// busy stays low, so one index may enter every cycle.
// each beat yields one result: done pulses for one cycle
// with curve_value and gamma_bad, and the receiver cannot stall.
// the result passes through the pipeline: table lookup, split gamma product,
// exp2 scaling, fifteen three-stage series terms, shift, range product,
// clamp and the 65535 scaling.
// throughput is one result per cycle.
// reset clears the valid chain and loads the register defaults
// (gamma 1.0, min 0, max 1.0); no beat in flight survives reset.
module gamma_formula_curve_eval (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [7:0]  entry_index,
    output logic        busy,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [15:0] curve_value,
    output logic        gamma_bad
);

    localparam int TERMS = 16;

    logic [31:0] gamma_reg, min_reg, max_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= gfc_pkg::GAMMA_RESET;
            min_reg   <= gfc_pkg::MIN_RESET;
            max_reg   <= gfc_pkg::MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gfc_pkg::REG_GAMMA: gamma_reg <= cfg_data;
                gfc_pkg::REG_MIN:   min_reg   <= cfg_data;
                gfc_pkg::REG_MAX:   max_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    logic accept;
    assign accept = start && !busy;

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic [7:0]  idx1_reg, idx2_reg, idx3_reg, idx5_reg;
    logic [33:0] u1_reg;
    logic [36:0] pp_lo_reg, pp_hi_reg;
    logic [6:0]  n3_reg;
    logic [30:0] f3_reg;
    gfc_pkg::tag_t tag4_reg;
    logic [31:0] a4_reg;
    logic [33:0] sum4_reg;
    logic [32:0] p5_reg;
    logic [63:0] prod6_reg;
    logic [48:0] y7_reg;
    logic [15:0] value8_reg;
    logic        bad8_reg;

    logic [53:0] t_next;
    logic [62:0] a_next;

    // gamma times log distance in two partial products
    assign t_next = (54'(pp_hi_reg) << 17) + 54'(pp_lo_reg);
    // fraction of the exponent times ln2
    assign a_next = 63'(f3_reg) * 63'(gfc_pkg::LN2_Q32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // front stages: lookup, partial products, exponent split, series start
    always_ff @(posedge clk)
    begin
        idx1_reg  <= entry_index;
        u1_reg    <= gfc_pkg::DIST_TABLE[entry_index];
        idx2_reg  <= idx1_reg;
        pp_lo_reg <= 37'(gamma_reg[19:0]) * 37'(u1_reg[16:0]);
        pp_hi_reg <= 37'(gamma_reg[19:0]) * 37'(u1_reg[33:17]);
        idx3_reg  <= idx2_reg;
        n3_reg    <= t_next[53:47];
        f3_reg    <= t_next[46:16];
        tag4_reg.idx   <= idx3_reg;
        tag4_reg.shift <= n3_reg;
        a4_reg    <= a_next[62:31];
        sum4_reg  <= 34'h1_0000_0000 - 34'(a_next[62:31]);
    end

    // series chain for terms two through sixteen
    logic                      sv  [TERMS];
    logic [31:0]               st  [TERMS];
    logic [31:0]               sa  [TERMS];
    logic [33:0]               ss  [TERMS];
    logic [gfc_pkg::TAG_W-1:0] stg [TERMS];

    assign sv[1]  = v4_reg;
    assign st[1]  = a4_reg;
    assign sa[1]  = a4_reg;
    assign ss[1]  = sum4_reg;
    assign stg[1] = tag4_reg;
    assign sv[0]  = 1'b0;
    assign st[0]  = '0;
    assign sa[0]  = '0;
    assign ss[0]  = '0;
    assign stg[0] = '0;

    for (genvar k = 2; k <= TERMS; k++)
    begin : g_term
        if (k < TERMS)
        begin : g_mid
            gfc_series_term #(.K(k)) u_term (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (sv[k-1]),
                .in_term   (st[k-1]),
                .in_a      (sa[k-1]),
                .in_sum    (ss[k-1]),
                .in_tag    (stg[k-1]),
                .out_valid (sv[k]),
                .out_term  (st[k]),
                .out_a     (sa[k]),
                .out_sum   (ss[k]),
                .out_tag   (stg[k])
            );
        end
        else
        begin : g_last
            logic                      lv;
            logic [31:0]               lt, la;
            logic [33:0]               ls;
            logic [gfc_pkg::TAG_W-1:0] ltag;
            gfc_series_term #(.K(k)) u_term (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (sv[k-1]),
                .in_term   (st[k-1]),
                .in_a      (sa[k-1]),
                .in_sum    (ss[k-1]),
                .in_tag    (stg[k-1]),
                .out_valid (lv),
                .out_term  (lt),
                .out_a     (la),
                .out_sum   (ls),
                .out_tag   (ltag)
            );
        end
    end

    logic                      fv;
    logic [33:0]               fsum;
    gfc_pkg::tag_t             ftag;
    logic                      unused_ok;
    assign fv        = g_term[TERMS].g_last.lv;
    assign fsum      = g_term[TERMS].g_last.ls;
    assign ftag      = gfc_pkg::tag_t'(g_term[TERMS].g_last.ltag);
    assign unused_ok = ^{g_term[TERMS].g_last.lt, g_term[TERMS].g_last.la, sv[0], st[0],
                         sa[0], ss[0], stg[0]};

    // power term, then range product, clamp and scale
    logic [32:0] p_next;
    logic        falling;
    logic [31:0] mag;
    logic [63:0] prod_next;
    logic [63:0] base;
    logic [64:0] rise_sum;
    logic [63:0] y_full;
    logic [48:0] y_next;
    logic [64:0] scaled;

    always_comb
    begin
        if (ftag.idx == 8'd0)
        begin
            p_next = '0;
        end
        else if (ftag.idx == 8'd255)
        begin
            p_next = 33'h1_0000_0000;
        end
        else if (ftag.shift >= 7'd33)
        begin
            p_next = '0;
        end
        else
        begin
            p_next = fsum[32:0] >> ftag.shift;
        end
    end

    assign falling   = max_reg < min_reg;
    assign mag       = falling ? min_reg - max_reg : max_reg - min_reg;
    assign prod_next = p5_reg[32] ? {mag, 32'd0} : 64'(mag) * 64'(p5_reg[31:0]);
    assign base      = {min_reg, 32'd0};
    assign rise_sum  = 65'(base) + 65'(prod6_reg);

    always_comb
    begin
        if (falling)
        begin
            y_full = (prod6_reg > base) ? 64'd0 : base - prod6_reg;
        end
        else
        begin
            y_full = rise_sum[64] ? '1 : rise_sum[63:0];
        end
        y_next = (y_full > 64'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : y_full[48:0];
    end

    assign scaled = (65'(y7_reg) << 16) - 65'(y7_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= fv;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    logic bad_now;
    assign bad_now = (gamma_reg < gfc_pkg::GAMMA_LOW_CODE) ||
                     (gamma_reg > gfc_pkg::GAMMA_HIGH_CODE);

    always_ff @(posedge clk)
    begin
        idx5_reg   <= ftag.idx;
        p5_reg     <= p_next;
        prod6_reg  <= prod_next;
        y7_reg     <= y_next;
        value8_reg <= bad_now ? 16'd0 : scaled[63:48];
        bad8_reg   <= bad_now | (unused_ok & 1'b0) | ((|idx5_reg) & 1'b0);
    end

    assign done        = v8_reg;
    assign curve_value = value8_reg;
    assign gamma_bad   = bad8_reg;

endmodule

### hw/rtl/gfc_checker.sv
// port-level checks for the gamma curve evaluator, bound to the top level
module gfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        cfg_ready,
    input logic        done,
    input logic [15:0] curve_value,
    input logic        gamma_bad
);

    localparam int LATENCY = 53;

    // the block never refuses an index beat
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // the configuration channel is always open
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg_ready dropped");

    // every result comes from a beat taken a fixed latency earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching input beat");

    // a bad gamma forces a zero value
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && gamma_bad) |-> (curve_value == 16'd0))
        else $error("nonzero value with bad gamma");

endmodule

bind gamma_formula_curve_eval gfc_checker u_gfc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cfg_ready   (cfg_ready),
    .done        (done),
    .curve_value (curve_value),
    .gamma_bad   (gamma_bad)
);
